/* rtl/lucd_pkg.sv */
package lucd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned PEND_D   = 3;
    localparam int unsigned BUF_D    = 4;
    localparam int unsigned RES_MAX  = 3;
    localparam int unsigned QUEUE_D  = 4;
    localparam int unsigned ODATA_W  = 24;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_PFX  = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_PFX  = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hf8;
    localparam logic [BYTE_W-1:0] LEAD4_PFX  = 8'hf0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3f;
    localparam logic [BYTE_W-1:0] L2_MASK    = 8'h1f;
    localparam logic [BYTE_W-1:0] L3_MASK    = 8'h0f;
    localparam logic [BYTE_W-1:0] L4_MASK    = 8'h07;
    localparam logic [CP_W-1:0]   CP_MIN     = 21'h00020;
    localparam logic [CP_W-1:0]   CP_DEL     = 21'h0007f;

    typedef logic [CP_W-1:0] t_cp;

    typedef struct packed {
        t_cp  cp;
        logic last;
    } t_res;

    typedef struct packed {
        logic [BUF_D-1:0]         vld;
        logic [BUF_D-1:0][CP_W-1:0] cp;
    } t_dec;

    // Sequence length announced by a lead byte: 2, 3, 4, else 1.
    function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        len = 3'd1;
        if ((b & LEAD2_MASK) == LEAD2_PFX) begin
            len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_PFX) begin
            len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_PFX) begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic cp_keep(input t_cp cp);
        return (cp >= CP_MIN) && (cp != CP_DEL);
    endfunction

    // Walk a buffer of up to four bytes; one candidate per start position.
    function automatic t_dec decode_buf(input logic [BUF_D-1:0][BYTE_W-1:0] bytes,
                                        input logic [2:0] n);
        t_dec              d;
        logic [2:0]        pos;
        logic [3:0]        sum;
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] c1;
        logic [BYTE_W-1:0] c2;
        logic [BYTE_W-1:0] c3;
        logic [2:0]        len;
        t_cp               cp;
        pos = 3'd0;
        d   = '0;
        for (int s = 0; s < BUF_D; s++) begin
            if (pos < n) begin
                lead = bytes[pos[1:0]];
                c1   = bytes[pos[1:0] + 2'd1] & CONT_MASK;
                c2   = bytes[pos[1:0] + 2'd2] & CONT_MASK;
                c3   = bytes[pos[1:0] + 2'd3] & CONT_MASK;
                len  = lead_len(lead);
                sum  = {1'b0, pos} + {1'b0, len};
                cp   = {13'd0, lead};
                if ((len > 3'd1) && (sum <= {1'b0, n})) begin
                    case (len)
                        3'd2:    cp = {10'd0, 5'(lead & L2_MASK), c1[5:0]};
                        3'd3:    cp = {5'd0, 4'(lead & L3_MASK), c1[5:0], c2[5:0]};
                        default: cp = {3'(lead & L4_MASK), c1[5:0], c2[5:0], c3[5:0]};
                    endcase
                    pos = sum[2:0];
                end else begin
                    pos = pos + 3'd1;
                end
                d.cp[s]  = cp;
                d.vld[s] = cp_keep(cp);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/lenient_utf8_codepoint_decoder.sv */
// Channel  Dir  tdata                       tlast         tuser
// s_axis   in   [7:0] data_byte             end_of_text   -
// m_axis   out  [20:0] code_point, 0 above  last_of_run   -
//
// Each accepted byte is decoded in the cycle it is taken; its results (0 to 3)
// land in a four-entry result queue that drains one transaction per cycle
// while m_axis_tready is high. A byte is taken whenever the queue holds at
// most one result, so one result per byte runs at one byte per clock unless
// the output stalls; extra results from a flush hold off the next input byte.
// Synchronous active-low reset empties the queue and closes any open sequence.
module lenient_utf8_codepoint_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lucd_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tlast,  // end_of_text
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lucd_pkg::ODATA_W-1:0]  m_axis_tdata,  // [20:0] code_point
    output logic                          m_axis_tlast   // last_of_run
);
    import lucd_pkg::*;

    logic [PEND_D-1:0][BYTE_W-1:0] r_pend;
    logic [1:0]                    r_cnt;
    logic [2:0]                    r_seq;
    t_res [QUEUE_D-1:0]            r_q;
    logic [2:0]                    r_occ;

    logic [PEND_D-1:0][BYTE_W-1:0] n_pend;
    logic [1:0]                    n_cnt;
    logic [2:0]                    n_seq;
    t_res [QUEUE_D-1:0]            n_q;
    logic [2:0]                    n_occ;

    logic                          acc;
    logic                          pop;
    logic [BUF_D-1:0][BYTE_W-1:0]  bytes;
    logic [2:0]                    n_bytes;
    logic [2:0]                    b_len;
    logic                          fire;
    t_dec                          dec;
    t_res [QUEUE_D-1:0]            slot;
    logic [2:0]                    k;
    logic [2:0]                    push;
    logic [2:0]                    rem;
    logic [2:0]                    off;

    assign s_axis_tready = (r_occ <= 3'd1);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_occ != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {3'd0, r_q[0].cp};
    assign m_axis_tlast  = r_q[0].last;

    always_comb begin
        bytes[0] = (r_cnt == 2'd0) ? s_axis_tdata : r_pend[0];
        bytes[1] = (r_cnt == 2'd1) ? s_axis_tdata : r_pend[1];
        bytes[2] = (r_cnt == 2'd2) ? s_axis_tdata : r_pend[2];
        bytes[3] = s_axis_tdata;
        n_bytes  = {1'b0, r_cnt} + 3'd1;
        b_len    = lead_len(s_axis_tdata);
        if (s_axis_tlast) begin
            fire = 1'b1;
        end else if (r_seq == 3'd0) begin
            fire = (b_len == 3'd1);
        end else begin
            fire = (n_bytes >= r_seq);
        end
        dec = decode_buf(bytes, n_bytes);
    end

    // Compact kept candidates into at most three result slots.
    always_comb begin
        slot = '0;
        k    = 3'd0;
        for (int s = 0; s < BUF_D; s++) begin
            if (dec.vld[s] && (k < 3'(RES_MAX))) begin
                slot[k[1:0]].cp = dec.cp[s];
                k = k + 3'd1;
            end
        end
        for (int j = 0; j < QUEUE_D; j++) begin
            slot[j].last = (k != 3'd0) && (3'(j) == k - 3'd1);
        end
    end

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        n_seq  = r_seq;
        if (acc) begin
            if (fire) begin
                n_cnt = 2'd0;
                n_seq = 3'd0;
            end else begin
                // hold the byte until the sequence completes
                n_pend[r_cnt] = s_axis_tdata;
                n_cnt         = n_bytes[1:0];
                if (r_seq == 3'd0) begin
                    n_seq = b_len;
                end
            end
        end
    end

    always_comb begin
        push  = (acc && fire) ? k : 3'd0;
        rem   = r_occ - {2'd0, pop};
        n_occ = rem + push;
        for (int j = 0; j < QUEUE_D; j++) begin
            off    = 3'(j) - rem;
            n_q[j] = r_q[j];
            if (3'(j) < rem) begin
                n_q[j] = r_q[2'(j) + {1'b0, pop}];
            end else if (off < push) begin
                n_q[j] = slot[off[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_seq <= 3'd0;
            r_occ <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
            r_seq <= n_seq;
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_q    <= n_q;
    end

endmodule

/* bench/lenient_utf8_codepoint_decoder_chk.sv */
`timescale 1ns / 1ps

module lenient_utf8_codepoint_decoder_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [lucd_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tlast,  // end_of_text
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [lucd_pkg::ODATA_W-1:0]  m_axis_tdata,  // [20:0] code_point, 0 above
    input  logic                          m_axis_tlast,  // last_of_run
    output int unsigned                   o_errors,
    output int unsigned                   o_due,
    output int unsigned                   o_checked
);
    import lucd_pkg::*;

    t_res        cp_due [$];
    t_res        want;
    logic [7:0]  held [PEND_D];
    int unsigned held_cnt;
    int unsigned open_len;
    t_cp         step_cps [RES_MAX];
    int unsigned step_k;
    int unsigned errors;
    int unsigned checked;
    int unsigned due_cnt;

    assign o_errors  = errors;
    assign o_checked = checked;
    assign o_due     = due_cnt;

    initial begin
        errors   = 0;
        checked  = 0;
        due_cnt  = 0;
        held_cnt = 0;
        open_len = 0;
    end

    function automatic int unsigned lead_span(input logic [7:0] b);
        int unsigned span;
        casez (b)
            8'b110?????: span = 2;
            8'b1110????: span = 3;
            8'b11110???: span = 4;
            default:     span = 1;
        endcase
        return span;
    endfunction

    // Drop control values and DEL; cap at three results per byte.
    function automatic void offer_cp(input t_cp cp);
        if (step_k < RES_MAX && cp >= CP_MIN && cp != CP_DEL) begin
            step_cps[step_k] = cp;
            step_k++;
        end
    endfunction

    function automatic void walk_bytes(input logic [3:0][7:0] bytes, input int unsigned n);
        int unsigned pos;
        int unsigned span;
        logic [7:0]  lead;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
        t_cp         cp;
        pos = 0;
        while (pos < n) begin
            lead = bytes[pos];
            span = lead_span(lead);
            cp   = t_cp'(lead);
            if (span > 1 && pos + span <= n) begin
                c1 = bytes[pos + 1];
                c2 = (pos + 2 < 4) ? bytes[pos + 2] : 8'h00;
                c3 = (pos + 3 < 4) ? bytes[pos + 3] : 8'h00;
                case (span)
                    2:       cp = t_cp'({lead[4:0], c1[5:0]});
                    3:       cp = t_cp'({lead[3:0], c1[5:0], c2[5:0]});
                    default: cp = t_cp'({lead[2:0], c1[5:0], c2[5:0], c3[5:0]});
                endcase
                pos += span;
            end else begin
                pos++;
            end
            offer_cp(cp);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eot);
        logic [3:0][7:0] bytes;
        int unsigned     n;
        int unsigned     i;
        t_res            r;
        bytes  = '0;
        n      = 0;
        step_k = 0;
        if (open_len != 0) begin
            for (i = 0; i < held_cnt; i++) begin
                bytes[i] = held[i];
            end
            n = held_cnt;
        end
        bytes[n] = b;
        n++;
        if (eot) begin
            // flush: held lead goes raw if short, the rest is decoded again
            walk_bytes(bytes, n);
            held_cnt = 0;
            open_len = 0;
        end else if (open_len == 0) begin
            if (lead_span(b) > 1) begin
                held[0]  = b;
                held_cnt = 1;
                open_len = lead_span(b);
            end else begin
                offer_cp(t_cp'(b));
                held_cnt = 0;
            end
        end else if (n >= open_len) begin
            walk_bytes(bytes, n);
            held_cnt = 0;
            open_len = 0;
        end else begin
            held[n - 1] = b;
            held_cnt    = n;
        end
        for (i = 0; i < step_k; i++) begin
            r.cp   = step_cps[i];
            r.last = (i == step_k - 1);
            cp_due = {cp_due, r};
        end
    endfunction

    task automatic flag_mismatch(input string field, input int unsigned exp_v,
                                 input int unsigned act_v);
        errors++;
        if (errors <= 10) begin
            $display("%0t: %s mismatch: expected 0x%06h, got 0x%06h",
                     $realtime, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cp_due.delete();
            held_cnt = 0;
            open_len = 0;
            due_cnt <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (cp_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: unexpected transaction tdata 0x%06h tlast %0b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    end
                end else begin
                    want = cp_due.pop_front();
                    checked++;
                    if (m_axis_tdata !== ODATA_W'(want.cp)) begin
                        flag_mismatch("code_point", 32'(want.cp), 32'(m_axis_tdata));
                    end
                    if (m_axis_tlast !== want.last) begin
                        flag_mismatch("last_of_run", 32'(want.last), 32'(m_axis_tlast));
                    end
                end
            end
            due_cnt <= cp_due.size();
        end
    end

endmodule

/* bench/tb_lenient_utf8_codepoint_decoder.sv */
`timescale 1ns / 1ps

module tb_lenient_utf8_codepoint_decoder;
    import lucd_pkg::*;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [ODATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;

    int unsigned errors;
    int unsigned due;
    int unsigned checked;
    int unsigned bytes_sent   = 0;
    int unsigned texts_closed = 0;
    bit          calm         = 1'b0;
    bit          rx_hold_go   = 1'b0;
    bit          rx_hold_done = 1'b0;

    // {end_of_text, data_byte}
    logic [8:0] opening_text [24] = '{
        9'h041, 9'h01f, 9'h07f, 9'h000, 9'h0ff, 9'h080, 9'h120,
        9'h0c3, 9'h0a9, 9'h0c0, 9'h081,
        9'h0e2, 9'h082, 9'h0ac,
        9'h0f7, 9'h0bf, 9'h0bf, 9'h0bf,
        9'h1e2,
        9'h0f0, 9'h041, 9'h142,
        9'h0f0, 9'h1c3
    };

    lenient_utf8_codepoint_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    lenient_utf8_codepoint_decoder_chk u_decode_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_errors      (errors),
        .o_due         (due),
        .o_checked     (checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d code points outstanding", due);
        $display("CHECKS FAILED");
        $finish;
    end

    // Output side: random backpressure, a calm stretch, and one long hold-off.
    initial begin
        @(posedge i_clk);
        forever begin
            if (rx_hold_go && !rx_hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge i_clk);
                rx_hold_done = 1'b1;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
                @(posedge i_clk);
            end
        end
    end

    // Call right after a rising edge; returns at the edge that takes the byte.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (!calm && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        if (eot) texts_closed++;
    endtask

    // Send the first count bytes of a well-formed character of the given span.
    task automatic send_char(input int unsigned span, input int unsigned count,
                             input bit eot);
        logic [7:0]  seq [4];
        int unsigned i;
        case (span)
            1:       seq[0] = 8'($urandom_range(0, 127));
            2:       seq[0] = {3'b110, 5'($urandom)};
            3:       seq[0] = {4'b1110, 4'($urandom)};
            default: seq[0] = {5'b11110, 3'($urandom)};
        endcase
        for (i = 1; i < 4; i++) begin
            seq[i] = {2'b10, 6'($urandom)};
        end
        for (i = 0; i < count; i++) begin
            send_byte(seq[i], eot && (i == count - 1));
        end
    endtask

    task automatic random_burst(input int unsigned n);
        int unsigned stop;
        int unsigned pick;
        int unsigned span;
        stop = bytes_sent + n;
        while (bytes_sent < stop) begin
            pick = $urandom_range(0, 99);
            span = $urandom_range(2, 4);
            if (pick < 60) begin
                span = $urandom_range(1, 4);
                send_char(span, span, $urandom_range(0, 9) == 0);
            end else if (pick < 75) begin
                send_char(span, $urandom_range(1, span - 1), 1'b1);
            end else if (pick < 85) begin
                send_char(span, $urandom_range(1, span - 1), 1'b0);
            end else begin
                send_byte(8'($urandom), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // Hold the input until every expected code point has come out.
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned i;
        int unsigned w;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 24; i++) begin
            send_byte(opening_text[i][7:0], opening_text[i][8]);
        end
        drain_all();

        random_burst(70);
        calm = 1'b1;
        random_burst(40);
        calm = 1'b0;
        rx_hold_go = 1'b1;
        random_burst(30);
        drain_all();
        random_burst(80);
        s_axis_tvalid <= 1'b0;

        w = 0;
        while (due != 0 && w < 5000) begin
            @(posedge i_clk);
            w++;
        end
        repeat (20) @(posedge i_clk);

        if (due != 0) begin
            $display("%0d expected code points never arrived", due);
        end
        $display("Fed %0d bytes over %0d text ends; compared %0d code points.",
                 bytes_sent, texts_closed, checked);
        $display("Mix: all sequence spans, cut-off texts, noise, a long output stall.");
        if (errors == 0 && due == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
